@@ rtl/wbps_pkg.sv @@
// Shared widths, register indexes and types for the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 48;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 3;
  localparam int LEN_W    = 6;
  localparam int WILD_W   = 32;
  localparam int PAT_WORDS = 4;
  localparam int PAT_BYTES = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD_MASK  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd5;

  typedef struct packed {
    logic             len_ok;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] len_m1;
  } len_info_t;

endpackage

@@ rtl/wbps_if.sv @@
// Valid/ready stream interfaces for the scanner's byte input and match result channels.
interface wbps_in_if;
  logic                        valid;
  logic                        ready;
  logic [wbps_pkg::BYTE_W-1:0] data_byte;
  logic [wbps_pkg::ADDR_W-1:0] byte_address;
  logic                        block_start;

  modport source (output valid, data_byte, byte_address, block_start, input ready);
  modport sink   (input valid, data_byte, byte_address, block_start, output ready);
endinterface

interface wbps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        match_found;
  logic [wbps_pkg::ADDR_W-1:0] match_address;

  modport source (output valid, match_found, match_address, input ready);
  modport sink   (input valid, match_found, match_address, output ready);
endinterface

@@ rtl/wildcard_byte_pattern_scanner.sv @@
// Wildcard byte pattern scanner: accepts one byte per clock unless stalled and returns one
// match result per byte. An accepted byte goes to the window register, its result then to
// the result register; the parallel compare of the whole window against the aligned
// pattern sets the rate of one byte per cycle, and a held result back-pressures the input
// only once both stages are full. Pattern, wildcard and length writes are re-aligned to
// window positions in registers behind the configuration registers, so a write followed
// by a byte on the next cycle already applies to it. Matches never span a block start;
// match_address is the address of the first matched byte modulo 2^48, zero when no match.
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wbps_in_if.sink                        in_chan,
  wbps_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]     cfg_data
);

  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1);

  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] pat_al;
  logic [MAX_PATTERN_BYTES-1:0]                       care_al;
  wbps_pkg::len_info_t                                len_info;
  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] win;
  logic [FILL_W-1:0]                                  fill;
  logic                                               s1_valid;
  logic [wbps_pkg::ADDR_W-1:0]                        s1_addr;
  logic                                               s1_take;

  wbps_cfg #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat_al    (pat_al),
    .care_al   (care_al),
    .len_info  (len_info)
  );

  wbps_window #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .s1_take  (s1_take),
    .s1_valid (s1_valid),
    .s1_addr  (s1_addr),
    .win      (win),
    .fill     (fill)
  );

  wbps_match #(.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_addr  (s1_addr),
    .win      (win),
    .fill     (fill),
    .pat_al   (pat_al),
    .care_al  (care_al),
    .len_info (len_info),
    .s1_take  (s1_take),
    .out_chan (out_chan)
  );

endmodule

@@ rtl/wbps_cfg.sv @@
// Configuration registers and the pattern/care masks aligned to window positions.
module wbps_cfg #(
  parameter int MAX_PATTERN_BYTES = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [wbps_pkg::CFG_W-1:0]                 cfg_data,
  output logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] pat_al,
  output logic [MAX_PATTERN_BYTES-1:0]               care_al,
  output wbps_pkg::len_info_t                        len_info
);

  logic [wbps_pkg::PAT_WORDS-1:0][wbps_pkg::CFG_W-1:0]     pat_words_r;
  logic [wbps_pkg::WILD_W-1:0]                             wild_r;
  logic [wbps_pkg::LEN_W-1:0]                              len_r;

  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0]      pat_al_r, pat_al_nxt;
  logic [MAX_PATTERN_BYTES-1:0]                            care_al_r, care_al_nxt;
  wbps_pkg::len_info_t                                     len_info_r, len_info_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_words_r <= '0;
      wild_r      <= '0;
      len_r       <= wbps_pkg::LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        wbps_pkg::CFG_PATTERN_WORD_0: pat_words_r[0] <= cfg_data;
        wbps_pkg::CFG_PATTERN_WORD_1: pat_words_r[1] <= cfg_data;
        wbps_pkg::CFG_PATTERN_WORD_2: pat_words_r[2] <= cfg_data;
        wbps_pkg::CFG_PATTERN_WORD_3: pat_words_r[3] <= cfg_data;
        wbps_pkg::CFG_WILDCARD_MASK:  wild_r <= cfg_data[wbps_pkg::WILD_W-1:0];
        wbps_pkg::CFG_PATTERN_LENGTH: len_r  <= cfg_data[wbps_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Window position j (0 = newest) pairs with pattern byte len-1-j.
  always_comb begin
    logic [wbps_pkg::LEN_W:0] kv;
    logic [wbps_pkg::PAT_BYTES*wbps_pkg::BYTE_W-1:0] pat_flat;
    pat_flat    = pat_words_r;
    pat_al_nxt  = '0;
    care_al_nxt = '0;
    kv          = '0;
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      kv = {1'b0, len_r} - (wbps_pkg::LEN_W+1)'(1) - (wbps_pkg::LEN_W+1)'(j);
      if ((wbps_pkg::LEN_W+1)'(j) < {1'b0, len_r}) begin
        if (kv[wbps_pkg::LEN_W:5] == '0) begin
          pat_al_nxt[j]  = pat_flat[{kv[4:0], 3'b000} +: wbps_pkg::BYTE_W];
          care_al_nxt[j] = !wild_r[kv[4:0]];
        end else begin
          care_al_nxt[j] = 1'b1;
        end
      end
    end
    len_info_nxt.len    = len_r;
    len_info_nxt.len_m1 = len_r - wbps_pkg::LEN_W'(1);
    len_info_nxt.len_ok = (len_r != '0) &&
                          ({1'b0, len_r} <= (wbps_pkg::LEN_W+1)'(MAX_PATTERN_BYTES));
  end

  always_ff @(posedge clk) begin
    pat_al_r   <= pat_al_nxt;
    care_al_r  <= care_al_nxt;
    len_info_r <= len_info_nxt;
  end

  assign pat_al   = pat_al_r;
  assign care_al  = care_al_r;
  assign len_info = len_info_r;

endmodule

@@ rtl/wbps_window.sv @@
// Input stage: byte window shift register, block fill count and the held address.
module wbps_window #(
  parameter int MAX_PATTERN_BYTES = 32,
  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  wbps_in_if.sink                                            in_chan,
  input  logic                                               s1_take,
  output logic                                               s1_valid,
  output logic [wbps_pkg::ADDR_W-1:0]                        s1_addr,
  output logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] win,
  output logic [FILL_W-1:0]                                  fill
);

  logic                                               s1_valid_r, s1_valid_nxt;
  logic [wbps_pkg::ADDR_W-1:0]                        addr_r;
  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]                                  fill_r, fill_nxt;
  logic                                               in_fire;

  assign in_chan.ready = rst_n && (!s1_valid_r || s1_take);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_take);

  always_comb begin
    win_nxt = win_r;
    for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) begin
      win_nxt[i] = win_r[i-1];
    end
    win_nxt[0] = in_chan.data_byte;
    if (in_chan.block_start) begin
      fill_nxt = FILL_W'(1);
    end else if (fill_r == FILL_W'(MAX_PATTERN_BYTES)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fill_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (in_fire) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_r  <= win_nxt;
      addr_r <= in_chan.byte_address;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_addr  = addr_r;
  assign win      = win_r;
  assign fill     = fill_r;

endmodule

@@ rtl/wbps_match.sv @@
// Parallel masked window compare, match address and the result register.
module wbps_match #(
  parameter int MAX_PATTERN_BYTES = 32,
  localparam int FILL_W = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               s1_valid,
  input  logic [wbps_pkg::ADDR_W-1:0]                        s1_addr,
  input  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] win,
  input  logic [FILL_W-1:0]                                  fill,
  input  logic [MAX_PATTERN_BYTES-1:0][wbps_pkg::BYTE_W-1:0] pat_al,
  input  logic [MAX_PATTERN_BYTES-1:0]                       care_al,
  input  wbps_pkg::len_info_t                                len_info,
  output logic                                               s1_take,
  wbps_out_if.source                                         out_chan
);

  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic                         hit;
  logic [wbps_pkg::ADDR_W-1:0]  addr_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         found_r;
  logic [wbps_pkg::ADDR_W-1:0]  addr_r;

  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      byte_ok[j] = !care_al[j] || (win[j] == pat_al[j]);
    end
  end

  assign hit = len_info.len_ok && (&byte_ok) &&
               ((wbps_pkg::LEN_W+1)'(fill) >= {1'b0, len_info.len});
  assign addr_nxt = hit ? (s1_addr - wbps_pkg::ADDR_W'(len_info.len_m1)) : '0;

  assign s1_take       = s1_valid && (!out_valid_r || out_chan.ready);
  assign out_valid_nxt = s1_take || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      found_r <= hit;
      addr_r  <= addr_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.match_found   = found_r;
  assign out_chan.match_address = addr_r;

endmodule

@@ rtl/wbps_checker.sv @@
// Port-level checks for the scanner and the bind that attaches them.
module wbps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        match_found,
  input logic [wbps_pkg::ADDR_W-1:0] match_address
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_ready_in_reset: assert property (@(posedge clk) !rst_n |-> !in_ready)
    else $error("input ready during reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && !out_ready) |->
      out_valid && $stable(match_found) && $stable(match_address))
    else $error("stalled result transaction changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && !out_ready && !in_ready) && !out_ready |-> !in_ready)
    else $error("input ready while both stages are held");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !match_found |-> match_address == '0)
    else $error("match address without match");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .match_found   (out_chan.match_found),
  .match_address (out_chan.match_address)
);

@@ dv/tb_wildcard_byte_pattern_scanner.sv @@
// Self-checking testbench for the wildcard byte pattern scanner: directed and random byte scans.
module tb_wildcard_byte_pattern_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [wbps_pkg::CFG_IDX_W-1:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [wbps_pkg::CFG_IDX_W-1:0] CFG_UNUSED_7 = 3'd7;
  localparam int RANDOM_BYTES = 1850;

  typedef struct packed {
    logic                        found;
    logic [wbps_pkg::ADDR_W-1:0] addr;
  } scan_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                           cfg_we;
  logic [wbps_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wbps_pkg::CFG_W-1:0]     cfg_data;

  wbps_in_if  in_chan();
  wbps_out_if out_chan();

  wildcard_byte_pattern_scanner u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scanner shadow state
  logic [wbps_pkg::BYTE_W-1:0] win [wbps_pkg::PAT_BYTES];
  int                          fill;
  logic [wbps_pkg::CFG_W-1:0]  pat_word [wbps_pkg::PAT_WORDS];
  logic [wbps_pkg::WILD_W-1:0] wild_mask;
  logic [wbps_pkg::LEN_W-1:0]  pat_len;

  scan_result_t                results_due [$];
  logic [wbps_pkg::ADDR_W-1:0] scan_addr;
  bit                          quiet;
  int                          errors;
  int                          bytes_sent;
  int                          rand_bytes;
  int                          hits_due;
  int                          configs;
  int                          ready_hold;

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic int sender_gap();
    if (quiet || $urandom_range(0, 9) < 6) return 0;
    return stall_len();
  endfunction

  function automatic logic [wbps_pkg::BYTE_W-1:0] pat_byte(int k);
    return pat_word[k / 8][(k % 8) * 8 +: 8];
  endfunction

  task automatic report_mismatch(string what, logic [wbps_pkg::ADDR_W-1:0] got,
                                 logic [wbps_pkg::ADDR_W-1:0] want);
    if (errors < 50)
      $display("ERROR @%0t: %s got %h want %h", $time, what, got, want);
    errors++;
  endtask

  task automatic predict_scan(input logic [wbps_pkg::BYTE_W-1:0] d,
                              input logic [wbps_pkg::ADDR_W-1:0] a, input logic s);
    scan_result_t r;
    logic hit;
    int len;
    if (s) begin
      foreach (win[i]) win[i] = '0;
      fill = 0;
    end
    for (int i = wbps_pkg::PAT_BYTES - 1; i > 0; i--) win[i] = win[i-1];
    win[0] = d;
    if (fill < wbps_pkg::PAT_BYTES) fill++;
    len = pat_len;
    hit = (len >= 1) && (len <= wbps_pkg::PAT_BYTES) && (fill >= len);
    for (int k = 0; k < len && hit; k++)
      if (!wild_mask[k] && pat_byte(k) != win[len-1-k]) hit = 1'b0;
    r.found = hit;
    r.addr  = hit ? a - wbps_pkg::ADDR_W'(len - 1) : '0;
    if (hit) hits_due++;
    results_due.insert(results_due.size(), r);
  endtask

  // called at a rising edge; returns at the edge where the transaction happens
  task automatic send_byte(input logic [wbps_pkg::BYTE_W-1:0] d,
                           input logic [wbps_pkg::ADDR_W-1:0] a, input logic s);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.data_byte    <= d;
    in_chan.byte_address <= a;
    in_chan.block_start  <= s;
    do @(posedge clk); while (!in_chan.ready);
    predict_scan(d, a, s);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wbps_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      wbps_pkg::CFG_PATTERN_WORD_0, wbps_pkg::CFG_PATTERN_WORD_1,
      wbps_pkg::CFG_PATTERN_WORD_2, wbps_pkg::CFG_PATTERN_WORD_3: pat_word[idx[1:0]] = val;
      wbps_pkg::CFG_WILDCARD_MASK:  wild_mask = val[wbps_pkg::WILD_W-1:0];
      wbps_pkg::CFG_PATTERN_LENGTH: pat_len = val[wbps_pkg::LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [wbps_pkg::CFG_W-1:0] w0,
                           input logic [wbps_pkg::CFG_W-1:0] w1,
                           input logic [wbps_pkg::CFG_W-1:0] w2,
                           input logic [wbps_pkg::CFG_W-1:0] w3,
                           input logic [wbps_pkg::CFG_W-1:0] mask_val,
                           input logic [wbps_pkg::CFG_W-1:0] len_val,
                           input bit junk);
    wait_drained();
    write_reg(wbps_pkg::CFG_PATTERN_WORD_0, w0);
    write_reg(wbps_pkg::CFG_PATTERN_WORD_1, w1);
    write_reg(wbps_pkg::CFG_PATTERN_WORD_2, w2);
    write_reg(wbps_pkg::CFG_PATTERN_WORD_3, w3);
    write_reg(wbps_pkg::CFG_WILDCARD_MASK, mask_val);
    write_reg(wbps_pkg::CFG_PATTERN_LENGTH, len_val);
    if (junk) begin
      write_reg(CFG_UNUSED_6, {$urandom, $urandom});
      write_reg(CFG_UNUSED_7, '1);
    end
    cfg_we <= 1'b0;
    configs++;
  endtask

  function automatic logic [wbps_pkg::ADDR_W-1:0] fresh_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return wbps_pkg::ADDR_W'({$urandom, $urandom});
    if (r < 75) return {wbps_pkg::ADDR_W{1'b1}} - wbps_pkg::ADDR_W'($urandom_range(0, 40));
    return wbps_pkg::ADDR_W'($urandom_range(0, 40));
  endfunction

  task automatic scan_byte(input logic [wbps_pkg::BYTE_W-1:0] d, input logic s);
    if (s) scan_addr = fresh_address();
    else scan_addr = scan_addr + wbps_pkg::ADDR_W'(1);
    send_byte(d, scan_addr, s);
    rand_bytes++;
  endtask

  task automatic noise_run(input int n);
    for (int i = 0; i < n; i++)
      scan_byte(wbps_pkg::BYTE_W'($urandom), $urandom_range(0, 19) == 0);
  endtask

  // pattern instance with random wildcard content, optionally damaged or cut by a block start
  task automatic inject_signature(input bit corrupt, input bit cut);
    int bad_k;
    int cut_k;
    logic [wbps_pkg::BYTE_W-1:0] b;
    noise_run($urandom_range(0, 3));
    bad_k = corrupt ? $urandom_range(0, pat_len - 1) : -1;
    cut_k = cut ? $urandom_range(1, wbps_pkg::PAT_BYTES - 1) : -1;
    for (int k = 0; k < pat_len; k++) begin
      b = wild_mask[k] ? wbps_pkg::BYTE_W'($urandom) : pat_byte(k);
      if (k == bad_k) b = b ^ (8'h01 << $urandom_range(0, 7));
      scan_byte(b, (k == 0 && $urandom_range(0, 2) == 0) || k == cut_k);
    end
  endtask

  task automatic test_reset_values();
    send_byte(8'h00, '0, 1'b1);
    send_byte(8'hFF, '1, 1'b0);
    send_byte(8'h00, '1, 1'b0);
  endtask

  task automatic test_length_limits();
    configure('0, '0, '0, '0, '1, 64'd0, 1'b0);
    send_byte(8'h00, 48'h1234, 1'b1);
    configure('0, '0, '0, '0, '1, 64'd33, 1'b0);
    send_byte(8'h00, 48'h1235, 1'b0);
    configure('1, '1, '1, '1, '1, {58'h3FF_FFFF_FFFF_FFFF, 6'd63}, 1'b0);
    send_byte(8'hFF, 48'h1236, 1'b0);
  endtask

  task automatic test_wildcard_block_start();
    configure(64'h0000_0000_00C3_5AA5, '0, '0, '0, 64'h2, 64'd3, 1'b0);
    // match whose first byte sits at the top of the address space
    send_byte(8'hA5, '1, 1'b1);
    send_byte(8'h00, 48'h0, 1'b0);
    send_byte(8'hC3, 48'h1, 1'b0);
    send_byte(8'hC3, 48'h2, 1'b0);
    // block start inside the pattern, then too few bytes
    send_byte(8'hA5, 48'h100, 1'b1);
    send_byte(8'h77, 48'h101, 1'b1);
    send_byte(8'hC3, 48'h102, 1'b0);
    send_byte(8'hA5, 48'h103, 1'b0);
    send_byte(8'hFF, 48'h104, 1'b0);
    send_byte(8'hC3, 48'h105, 1'b0);
  endtask

  task automatic test_ignored_index();
    configure(64'h3C, '0, '0, '0, '0, 64'd1, 1'b1);
    send_byte(8'h3C, 48'h8000_0000_0000, 1'b1);
    send_byte(8'hC3, 48'h8000_0000_0001, 1'b0);
  endtask

  task automatic random_config(input int phase);
    logic [wbps_pkg::CFG_W-1:0]  w [wbps_pkg::PAT_WORDS];
    logic [wbps_pkg::WILD_W-1:0] m;
    int len;
    foreach (w[i]) w[i] = {$urandom, $urandom};
    m = $urandom & $urandom & $urandom;
    len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                     : $urandom_range(7, wbps_pkg::PAT_BYTES);
    case (phase % 8)
      0: begin
        m = '0;
        len = wbps_pkg::PAT_BYTES;
      end
      1: begin
        m = '1;
        len = wbps_pkg::PAT_BYTES;
      end
      2: begin
        m = '0;
        len = 1;
      end
      3: len = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(wbps_pkg::PAT_BYTES + 1, 63);
      4: foreach (w[i]) w[i] = (phase % 16 == 4) ? '0 : '1;
      default: ;
    endcase
    configure(w[0], w[1], w[2], w[3], {$urandom, m}, {26'($urandom), $urandom, 6'(len)},
              $urandom_range(0, 3) == 0);
  endtask

  task automatic test_random_scan();
    int phase;
    int budget;
    bit live;
    phase = 0;
    scan_addr = fresh_address();
    while (rand_bytes < RANDOM_BYTES) begin
      random_config(phase);
      quiet = (phase % 5 == 2);
      live = (pat_len >= 1) && (pat_len <= wbps_pkg::PAT_BYTES);
      budget = rand_bytes + (live ? 160 : 40);
      while (rand_bytes < budget) begin
        if (live && $urandom_range(0, 99) < 70)
          inject_signature($urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
        else
          noise_run($urandom_range(1, 8));
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
      phase++;
    end
    quiet = 1'b0;
  endtask

  // result sink stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      ready_hold = 0;
      out_chan.ready <= 1'b1;
    end else begin
      if (ready_hold == 0 && !quiet && $urandom_range(0, 3) == 0) ready_hold = stall_len();
      if (ready_hold > 0) begin
        ready_hold = ready_hold - 1;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch("unexpected result, match_address", out_chan.match_address, '0);
      end else begin
        want = results_due.pop_front();
        if (out_chan.match_found !== want.found)
          report_mismatch("match_found", wbps_pkg::ADDR_W'(out_chan.match_found),
                          wbps_pkg::ADDR_W'(want.found));
        if (out_chan.match_address !== want.addr)
          report_mismatch("match_address", out_chan.match_address, want.addr);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("wildcard_byte_pattern_scanner: mismatch");
    $finish;
  end

  initial begin
    in_chan.valid        = 1'b0;
    in_chan.data_byte    = '0;
    in_chan.byte_address = '0;
    in_chan.block_start  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    foreach (win[i]) win[i] = '0;
    foreach (pat_word[i]) pat_word[i] = '0;
    fill       = 0;
    wild_mask  = '0;
    pat_len    = 6'd1;
    quiet      = 1'b0;
    errors     = 0;
    bytes_sent = 0;
    rand_bytes = 0;
    hits_due   = 0;
    configs    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_length_limits();
    test_wildcard_block_start();
    test_ignored_index();
    test_random_scan();

    wait_drained();
    repeat (8) @(posedge clk);
    if (results_due.size() != 0)
      report_mismatch("results never returned", wbps_pkg::ADDR_W'(results_due.size()), '0);
    $display("Scanned %0d bytes (%0d random) under %0d pattern settings, %0d expected matches,",
             bytes_sent, rand_bytes, configs, hits_due);
    $display("with wildcards, block starts, address wrap and out-of-range lengths.");
    if (errors == 0) begin
      $display("wildcard_byte_pattern_scanner: match");
    end else begin
      $display("wildcard_byte_pattern_scanner: mismatch");
    end
    $finish;
  end

endmodule
